/* rtl/lfu_pkg.sv */
// Package for the LFU cache table: sizes, codes and request/response types.
// Used by lfu_front, lfu_engine and lfu_cache_table_core; depends on nothing.
`default_nettype none
package lfu_pkg;
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned USED_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned RANK_W  = IDX_W;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [CAP_W-1:0]  CAP_RESET    = CAP_W'(ENTRIES);
  localparam logic [ADDR_W-1:0] REG_CAPACITY = '0;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_e;

  typedef struct packed {
    func_e              func;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [VAL_W-1:0]   read_value;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
  } rsp_t;
endpackage
`default_nettype wire

/* rtl/lfu_front.sv */
// Front end: two-deep request queue between the stream input and the engine.
// Depends on lfu_pkg.
`default_nettype none
module lfu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire lfu_pkg::req_t in_req_i,
  output logic               req_valid_o,
  input  wire logic          req_ready_i,
  output lfu_pkg::req_t      req_o
);
  localparam int unsigned PTR_W = $clog2(lfu_pkg::FIFO_DEPTH);

  lfu_pkg::req_t                          mem_q [lfu_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]                       wptr_q, rptr_q;
  logic [$clog2(lfu_pkg::FIFO_DEPTH+1)-1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != ($clog2(lfu_pkg::FIFO_DEPTH+1))'(lfu_pkg::FIFO_DEPTH));
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = mem_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_req_i;
  end
endmodule
`default_nettype wire

/* rtl/lfu_engine.sv */
// Back end: scans the table one entry a cycle, then applies the get/put.
// Holds the table state and the result register. Depends on lfu_pkg.
`default_nettype none
module lfu_engine (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [lfu_pkg::CAP_W-1:0] cap_i,
  input  wire logic                      req_valid_i,
  output logic                           req_ready_o,
  input  wire lfu_pkg::req_t             req_i,
  output logic                           rsp_valid_o,
  input  wire logic                      rsp_ready_i,
  output lfu_pkg::rsp_t                  rsp_o
);
  localparam int unsigned IW = lfu_pkg::IDX_W;
  localparam int unsigned N  = lfu_pkg::ENTRIES;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic                      valid_q [N];
  logic [lfu_pkg::KEY_W-1:0] key_q   [N];
  logic [lfu_pkg::VAL_W-1:0] val_q   [N];
  logic [lfu_pkg::CNT_W-1:0] cnt_q   [N];
  logic [lfu_pkg::RANK_W-1:0] rank_q [N];

  lfu_pkg::req_t req_q;
  logic [IW-1:0] idx_q;
  logic found_q, victim_q, free_q;
  logic [IW-1:0] fidx_q, vidx_q, free_idx_q;
  logic [lfu_pkg::VAL_W-1:0]  fval_q;
  logic [lfu_pkg::KEY_W-1:0]  vkey_q;
  logic [lfu_pkg::CNT_W-1:0]  vcnt_q;
  logic [lfu_pkg::RANK_W-1:0] vrank_q;
  logic [lfu_pkg::USED_W-1:0] used_q;

  logic rsp_valid_q;
  lfu_pkg::rsp_t rsp_q;

  // update decision
  logic [lfu_pkg::USED_W-1:0] cap_eff;
  logic upd_fire, do_use, do_ins, do_ev, all_age;
  logic [IW-1:0] slot;
  logic [lfu_pkg::RANK_W-1:0] old_rank;
  lfu_pkg::rsp_t rsp_d;
  logic take_victim;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign upd_fire    = (state_q == S_UPD) && (!rsp_valid_q || rsp_ready_i);
  assign cap_eff     = (cap_i > lfu_pkg::CAP_W'(N)) ? lfu_pkg::USED_W'(N)
                                                    : lfu_pkg::USED_W'(cap_i);
  assign take_victim = valid_q[idx_q] && (!victim_q || (cnt_q[idx_q] < vcnt_q) ||
                       ((cnt_q[idx_q] == vcnt_q) && (rank_q[idx_q] > vrank_q)));

  always_comb begin
    rsp_d    = '0;
    do_use   = 1'b0;
    do_ins   = 1'b0;
    do_ev    = 1'b0;
    all_age  = 1'b0;
    slot     = fidx_q;
    old_rank = rank_q[fidx_q];
    if (req_q.func == lfu_pkg::FUNC_GET) begin
      if (found_q) begin
        rsp_d.hit        = 1'b1;
        rsp_d.read_value = fval_q;
        do_use           = 1'b1;
      end
    end else if (cap_eff != '0) begin
      if (found_q) begin
        rsp_d.hit = 1'b1;
        do_use    = 1'b1;
      end else begin
        do_ev   = (used_q >= cap_eff) && victim_q;
        slot    = do_ev ? vidx_q : free_idx_q;
        do_ins  = do_ev || free_q;
        // Ranks stay packed: on eviction only entries newer than the victim move up.
        all_age = !do_ev;
        if (do_ev) begin
          old_rank          = vrank_q;
          rsp_d.evicted     = 1'b1;
          rsp_d.evicted_key = vkey_q;
        end
      end
    end
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_valid_i) state_d = S_SCAN;
      S_SCAN: if (idx_q == IW'(N - 1)) state_d = S_UPD;
      S_UPD:  if (upd_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) valid_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_fire) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
      if (upd_fire && do_ins) valid_q[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_valid_i) begin
      req_q    <= req_i;
      idx_q    <= '0;
      found_q  <= 1'b0;
      victim_q <= 1'b0;
      free_q   <= 1'b0;
      used_q   <= '0;
    end
    if (state_q == S_SCAN) begin
      idx_q <= idx_q + 1'b1;
      if (valid_q[idx_q]) begin
        used_q <= used_q + 1'b1;
        if (!found_q && key_q[idx_q] == req_q.key) begin
          found_q <= 1'b1;
          fidx_q  <= idx_q;
          fval_q  <= val_q[idx_q];
        end
      end else if (!free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= idx_q;
      end
      if (take_victim) begin
        victim_q <= 1'b1;
        vidx_q   <= idx_q;
        vkey_q   <= key_q[idx_q];
        vcnt_q   <= cnt_q[idx_q];
        vrank_q  <= rank_q[idx_q];
      end
    end
    if (upd_fire) begin
      rsp_q <= rsp_d;
      if (do_use || do_ins) begin
        for (int j = 0; j < N; j++) begin
          if (IW'(j) != slot && valid_q[j] && (all_age || rank_q[j] < old_rank))
            rank_q[j] <= rank_q[j] + 1'b1;
        end
        rank_q[slot] <= '0;
      end
      if (do_use) begin
        if (cnt_q[slot] != '1) cnt_q[slot] <= cnt_q[slot] + 1'b1;
        if (req_q.func == lfu_pkg::FUNC_PUT) val_q[slot] <= req_q.value;
      end
      if (do_ins) begin
        key_q[slot] <= req_q.key;
        val_q[slot] <= req_q.value;
        cnt_q[slot] <= lfu_pkg::CNT_W'(1);
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/lfu_cache_table_core.sv */
// LFU cache table, top level: stream ports, APB capacity register, front queue, engine.
// Each request passes through the front queue, then the engine starts it, scans every table
// entry and updates; the engine takes no new request until the last result is registered.
// The two-deep front queue takes new requests while the engine works or a result waits.
// Reset (rst_ni low, async): table empty, queue empty, capacity = 16.
// Depends on lfu_pkg, lfu_front, lfu_engine.
`default_nettype none
module lfu_cache_table_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // request stream
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [63:0]                s_axis_tdata,  // key[31:0], value[63:32]
  input  wire logic [0:0]                 s_axis_tuser,  // func[0]
  // response stream
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [63:0]                     m_axis_tdata,  // read_value[31:0], evicted_key[63:32]
  output logic [1:0]                      m_axis_tuser,  // hit[0], evicted[1]
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lfu_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  logic [lfu_pkg::CAP_W-1:0] cap_q;
  lfu_pkg::req_t in_req, eng_req;
  lfu_pkg::rsp_t rsp;
  logic req_valid, req_ready;

  // capacity register, written on the APB access phase
  assign pready = 1'b1;
  assign prdata = (paddr == lfu_pkg::REG_CAPACITY) ? 32'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lfu_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && paddr == lfu_pkg::REG_CAPACITY) begin
      cap_q <= pwdata[lfu_pkg::CAP_W-1:0];
    end
  end

  assign in_req.func  = lfu_pkg::func_e'(s_axis_tuser[0]);
  assign in_req.key   = s_axis_tdata[31:0];
  assign in_req.value = s_axis_tdata[63:32];

  lfu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (in_req),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (eng_req)
  );

  // engine: scan for match, free slot and LFU/LRU victim, then update
  lfu_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (eng_req),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_o       (rsp)
  );

  assign m_axis_tdata = {rsp.evicted_key, rsp.read_value};
  assign m_axis_tuser = {rsp.evicted, rsp.hit};
endmodule
`default_nettype wire
